[rtl/lrs_pkg.sv]
package lrs_pkg;

    localparam int MAX_REGIONS = 1024;
    localparam int LBL_W       = 10;
    localparam int CNT_W       = 23;
    localparam int CRD_W       = 11;
    localparam int DIM_W       = 12;
    localparam int RGN_W       = 11;
    localparam int EPOCH_W     = 8;
    localparam int QDEPTH      = 2;
    localparam int ADDR_W      = 4;

    localparam logic [DIM_W-1:0] MAX_DIM = 12'd2048;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // first live frame tag; tag 0 marks an empty record
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;

    localparam logic ACT_ACCUM = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam logic [ADDR_W-1:0] REG_BLOB   = 4'h0;
    localparam logic [ADDR_W-1:0] REG_WIDTH  = 4'h4;
    localparam logic [ADDR_W-1:0] REG_HEIGHT = 4'h8;
    localparam logic [ADDR_W-1:0] REG_REGION = 4'hC;

    // classified command passed from the front to the back
    typedef struct packed {
        logic                 is_read;
        logic                 in_range;
        logic [EPOCH_W-1:0]   epoch;
        logic [LBL_W-1:0]     label;
        logic [CRD_W-1:0]     pos_x;
        logic [CRD_W-1:0]     pos_y;
        logic [23:0]          rgb;
        logic [7:0]           grey;
        logic [23:0]          seg_color;
        logic                 vote;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] pixel_count;
        logic [CRD_W-1:0] first_x;
        logic [CRD_W-1:0] first_y;
        logic [23:0]      first_rgb;
        logic [7:0]       first_grey;
        logic [23:0]      first_seg_color;
        logic [DIM_W-1:0] box_xmin;
        logic [CRD_W-1:0] box_xmax;
        logic [DIM_W-1:0] box_ymin;
        logic [CRD_W-1:0] box_ymax;
        logic [CNT_W-1:0] vote_count;
    } rec_t;

    function automatic logic [DIM_W-1:0] empty_min(input logic [DIM_W-1:0] dim);
        return (dim > MAX_DIM) ? MAX_DIM : dim;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

[rtl/labeled_region_statistics.sv]
// Labeled region statistics.
// Input channel (valid/stall): one transfer is either a labeled pixel to fold
// into its region record (action 0) or a read of one record (action 1).
// frame_start on any transfer empties every record before that transfer acts.
// Output channel (valid/stall): one transfer per read carrying the record; an
// empty/out-of-range one reads zeros, box (width,0,height,0) capped at 2048.
// Configuration through the APB port: blob_enable 0x0, image_width 0x4,
// image_height 0x8, region_count 0xC; write only while idle.
// The back end takes one transfer at a time and finishes it before the next,
// by a read-modify-write of the record memory (read, update/write, output).
// A two-entry queue between front and back takes up to two transfers ahead.
// A read passes the queue, IDLE, READ, EXEC and OUT to the result register.
// When the output is stalled the result holds in its register and the back
// end waits at its next read; the queue then fills and input stall rises.
// Records are tagged with an 8-bit frame counter, so a frame start needs no
// clearing, except that every 255th one starts a clearing pass over all tags.
// Reset: registers at 0/640/480/1024, no pending output; a tag clearing pass
// empties all records while the queue fills and stalls input.
module labeled_region_statistics (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic        frame_start,
    input  logic [9:0]  label,
    input  logic [10:0] pos_x,
    input  logic [10:0] pos_y,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  grey,
    input  logic [23:0] seg_color,
    input  logic        in_blob,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [22:0] pixel_count,
    output logic [10:0] first_x,
    output logic [10:0] first_y,
    output logic [23:0] first_rgb,
    output logic [7:0]  first_grey,
    output logic [23:0] first_seg_color,
    output logic [11:0] box_xmin,
    output logic [10:0] box_xmax,
    output logic [11:0] box_ymin,
    output logic [10:0] box_ymax,
    output logic [22:0] vote_count
);
    import lrs_pkg::*;

    logic        blob_enable_reg;
    logic [11:0] image_width_reg;
    logic [11:0] image_height_reg;
    logic [10:0] region_count_reg;
    logic        wr;
    cmd_t        q_data;
    logic        q_valid, q_pop;
    rec_t        res;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blob_enable_reg  <= 1'b0;
            image_width_reg  <= 12'd640;
            image_height_reg <= 12'd480;
            region_count_reg <= 11'd1024;
        end
        else if (wr)
        begin
            unique case (paddr)
                REG_BLOB:   blob_enable_reg  <= pwdata[0];
                REG_WIDTH:  image_width_reg  <= pwdata[11:0];
                REG_HEIGHT: image_height_reg <= pwdata[11:0];
                REG_REGION: region_count_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_BLOB:   prdata = {31'd0, blob_enable_reg};
            REG_WIDTH:  prdata = {20'd0, image_width_reg};
            REG_HEIGHT: prdata = {20'd0, image_height_reg};
            REG_REGION: prdata = {21'd0, region_count_reg};
            default:    prdata = 32'd0;
        endcase
    end

    lrs_front u_front (
        .clk, .rst_n,
        .valid(in_valid), .stall(in_stall),
        .action, .frame_start, .label, .pos_x, .pos_y,
        .red, .green, .blue, .grey, .seg_color, .in_blob,
        .blob_enable(blob_enable_reg), .region_count(region_count_reg),
        .q_data, .q_valid, .q_pop
    );

    lrs_back u_back (
        .clk, .rst_n,
        .q_data, .q_valid, .q_pop,
        .image_width(image_width_reg), .image_height(image_height_reg),
        .res_data(res), .res_valid(out_valid), .res_stall(out_stall)
    );

    assign pixel_count     = res.pixel_count;
    assign first_x         = res.first_x;
    assign first_y         = res.first_y;
    assign first_rgb       = res.first_rgb;
    assign first_grey      = res.first_grey;
    assign first_seg_color = res.first_seg_color;
    assign box_xmin        = res.box_xmin;
    assign box_xmax        = res.box_xmax;
    assign box_ymin        = res.box_ymin;
    assign box_ymax        = res.box_ymax;
    assign vote_count      = res.vote_count;

endmodule

[rtl/lrs_front.sv]
module lrs_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid,
    output logic                  stall,
    input  logic                  action,
    input  logic                  frame_start,
    input  logic [9:0]            label,
    input  logic [10:0]           pos_x,
    input  logic [10:0]           pos_y,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic [7:0]            grey,
    input  logic [23:0]           seg_color,
    input  logic                  in_blob,
    input  logic                  blob_enable,
    input  logic [10:0]           region_count,
    output lrs_pkg::cmd_t         q_data,
    output logic                  q_valid,
    input  logic                  q_pop
);
    import lrs_pkg::*;

    cmd_t                q_mem [QDEPTH];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          fill_reg, fill_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic                push;
    cmd_t                cmd;

    assign stall = (fill_reg == 2'(QDEPTH));
    assign push  = valid && !stall;

    // frame start opens a new epoch; older records then read as empty.
    // the counter skips 0, which tags empty records
    assign epoch_next = (push && frame_start) ?
                        ((epoch_reg == '1) ? EPOCH_FIRST : epoch_reg + 1'b1) : epoch_reg;

    always_comb
    begin
        cmd.is_read   = (action == ACT_READ);
        cmd.in_range  = ({1'b0, label} < region_count);
        cmd.epoch     = epoch_next;
        cmd.label     = label;
        cmd.pos_x     = pos_x;
        cmd.pos_y     = pos_y;
        cmd.rgb       = {red, green, blue};
        cmd.grey      = grey;
        cmd.seg_color = seg_color;
        cmd.vote      = blob_enable && in_blob;
    end

    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
    assign fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    assign q_valid     = (fill_reg != 2'd0);
    assign q_data      = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
            epoch_reg  <= EPOCH_FIRST;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            epoch_reg  <= epoch_next;
        end
    end

endmodule

[rtl/lrs_back.sv]
module lrs_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lrs_pkg::cmd_t         q_data,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  logic [11:0]           image_width,
    input  logic [11:0]           image_height,
    output lrs_pkg::rec_t         res_data,
    output logic                  res_valid,
    input  logic                  res_stall
);
    import lrs_pkg::*;

    // record memory plus per-entry frame tag; tag mismatch means empty.
    // tag 0 is never a live frame. A clearing pass writes 0 to every tag
    // after reset and whenever the frame counter wraps, so a stale tag
    // can never match a later frame.
    rec_t               rec_mem   [MAX_REGIONS];
    logic [EPOCH_W-1:0] tag_mem   [MAX_REGIONS];

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_OUT   = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;

    localparam logic [EPOCH_W-1:0] TAG_EMPTY = '0;

    logic [2:0]         state_reg, state_next;
    logic [LBL_W-1:0]   clr_cnt_reg, clr_cnt_next;
    cmd_t               cmd_reg;
    rec_t               rd_rec_reg;
    logic [EPOCH_W-1:0] rd_tag_reg;
    logic [EPOCH_W-1:0] last_epoch_reg, last_epoch_next;
    logic               wrap;
    logic               hit;
    rec_t               base, upd;
    logic               wr_en;
    logic               tag_we;
    logic [LBL_W-1:0]   tag_addr;
    logic [EPOCH_W-1:0] tag_wdata;
    rec_t               res_reg;
    logic               res_valid_reg;

    // head command starts the first frame after a counter wrap
    assign wrap = (q_data.epoch == EPOCH_FIRST) && (last_epoch_reg != EPOCH_FIRST);
    assign last_epoch_next = ((state_reg == ST_IDLE) && q_valid) ? q_data.epoch
                                                                 : last_epoch_reg;
    assign clr_cnt_next = (state_reg == ST_CLEAR) ? clr_cnt_reg + 1'b1 : '0;

    assign hit = (rd_tag_reg == cmd_reg.epoch) && cmd_reg.in_range;

    always_comb
    begin
        base = rd_rec_reg;
        if (!hit)
        begin
            base                 = '0;
            base.box_xmin        = empty_min(image_width);
            base.box_ymin        = empty_min(image_height);
            if (!cmd_reg.is_read)
            begin
                base.first_x         = cmd_reg.pos_x;
                base.first_y         = cmd_reg.pos_y;
                base.first_rgb       = cmd_reg.rgb;
                base.first_grey      = cmd_reg.grey;
                base.first_seg_color = cmd_reg.seg_color;
            end
        end
        upd = base;
        upd.pixel_count = sat_inc(base.pixel_count);
        if ({1'b0, cmd_reg.pos_x} < base.box_xmin) upd.box_xmin = {1'b0, cmd_reg.pos_x};
        if (cmd_reg.pos_x > base.box_xmax)         upd.box_xmax = cmd_reg.pos_x;
        if ({1'b0, cmd_reg.pos_y} < base.box_ymin) upd.box_ymin = {1'b0, cmd_reg.pos_y};
        if (cmd_reg.pos_y > base.box_ymax)         upd.box_ymax = cmd_reg.pos_y;
        if (cmd_reg.vote) upd.vote_count = sat_inc(base.vote_count);
    end

    assign wr_en = (state_reg == ST_EXEC) && !cmd_reg.is_read && cmd_reg.in_range;

    // one tag write port shared by the clearing pass and record updates
    assign tag_we    = wr_en || (state_reg == ST_CLEAR);
    assign tag_addr  = (state_reg == ST_CLEAR) ? clr_cnt_reg : cmd_reg.label;
    assign tag_wdata = (state_reg == ST_CLEAR) ? TAG_EMPTY : cmd_reg.epoch;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (wrap)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        q_pop      = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:  state_next = ST_EXEC;
            ST_EXEC:  state_next = cmd_reg.is_read ? ST_OUT : ST_IDLE;
            ST_OUT:   state_next = (!res_valid_reg || !res_stall) ? ST_IDLE : ST_OUT;
            ST_CLEAR: state_next = (clr_cnt_reg == '1) ? ST_IDLE : ST_CLEAR;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_data;
        end
        if (state_reg == ST_READ)
        begin
            rd_rec_reg <= rec_mem[cmd_reg.label];
            rd_tag_reg <= tag_mem[cmd_reg.label];
        end
        if (wr_en)
        begin
            rec_mem[cmd_reg.label] <= upd;
        end
        if (tag_we)
        begin
            tag_mem[tag_addr] <= tag_wdata;
        end
        if ((state_reg == ST_OUT) && (!res_valid_reg || !res_stall))
        begin
            res_reg <= base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            last_epoch_reg <= EPOCH_FIRST;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            last_epoch_reg <= last_epoch_next;
            if ((state_reg == ST_OUT) && (!res_valid_reg || !res_stall))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_data  = res_reg;
    assign res_valid = res_valid_reg;

endmodule

[rtl/lrs_checker.sv]
module lrs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [22:0] pixel_count,
    input logic [22:0] vote_count,
    input logic [10:0] box_xmax,
    input logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_count))
        else $error("stalled result changed");

    a_votes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> vote_count <= pixel_count)
        else $error("votes exceed pixel count");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_count == 23'd0 |-> box_xmax == 11'd0 && vote_count == 23'd0)
        else $error("empty record not clean");

    a_ready: assert property (@(posedge clk) pready)
        else $error("pready low");

endmodule

bind labeled_region_statistics lrs_checker u_chk (
    .clk, .rst_n, .out_valid, .out_stall,
    .pixel_count, .vote_count, .box_xmax, .pready
);
